// ===== hdl/bgtf_pkg.sv =====
package bgtf_pkg;

  // Defaults for the top-level parameters.
  localparam int LAYER_ID_DEFAULT  = 0;
  localparam int MEM_WORDS_DEFAULT = 32768;

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_MODE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLOR_DEPTH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BIG_TILES   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAP_SIZE    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MAP_BASE    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CHAR_BASE   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_X    = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_Y    = 3'd7;

  // Operation codes of an input transaction.
  localparam logic OP_FETCH = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Screen mode codes with special meaning.
  localparam logic [2:0] MODE_LAYER_PAL = 3'd0;
  localparam logic [2:0] MODE_HIRES_A   = 3'd5;
  localparam logic [2:0] MODE_HIRES_B   = 3'd6;

  // Color depth codes.
  localparam logic [1:0] DEPTH_2BPP = 2'd0;
  localparam logic [1:0] DEPTH_4BPP = 2'd1;

  // Field widths.
  localparam int PIXEL_X_W  = 10;
  localparam int LINE_Y_W   = 8;
  localparam int VADDR_W    = 15;
  localparam int VDATA_W    = 16;
  localparam int CHAR_W     = 12;
  localparam int FINE_ROW_W = 3;
  localparam int PALETTE_W  = 8;
  localparam int OUT_BITS_W = VADDR_W + CHAR_W + FINE_ROW_W + 1 + 1 + PALETTE_W;

  // Map geometry: screen-quadrant offsets in map words.
  localparam logic [12:0] QUAD_X_OFFSET  = 13'd1024;
  localparam logic [12:0] QUAD_Y_OFFSET  = 13'd1024;
  localparam logic [12:0] QUAD_Y_OFFSET2 = 13'd2048;
  localparam logic [10:0] SUB_TILE_DOWN  = 11'd16;

endpackage

// ===== hdl/bgtf_if.sv =====
// Input channel: a fetch request or a video memory word write.
interface bgtf_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 operation;
  logic signed [bgtf_pkg::PIXEL_X_W-1:0] pixel_x;
  logic [bgtf_pkg::LINE_Y_W-1:0]        line_y;
  logic [bgtf_pkg::VADDR_W-1:0]         write_address;
  logic [bgtf_pkg::VDATA_W-1:0]         write_data;

  modport source (output valid, operation, pixel_x, line_y, write_address, write_data,
                  input ready);
  modport sink (input valid, operation, pixel_x, line_y, write_address, write_data,
                output ready);
endinterface

// Output channel: one tile descriptor per input transaction.
interface bgtf_out_if;
  logic                            valid;
  logic                            ready;
  logic [bgtf_pkg::VADDR_W-1:0]    map_word_address;
  logic [bgtf_pkg::CHAR_W-1:0]     char_index;
  logic [bgtf_pkg::FINE_ROW_W-1:0] fine_row;
  logic                            flip_x;
  logic                            priority_bit;
  logic [bgtf_pkg::PALETTE_W-1:0]  palette_base;

  modport source (output valid, map_word_address, char_index, fine_row, flip_x,
                  priority_bit, palette_base, input ready);
  modport sink (input valid, map_word_address, char_index, fine_row, flip_x,
                priority_bit, palette_base, output ready);
endinterface

// ===== hdl/bgtf_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
module bgtf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/bg_tilemap_fetch.sv =====
// Channel | Direction | Handshake          | Contents
// in_ch   | in        | valid/ready        | operation, pixel_x, line_y, write_address, write_data
// out_ch  | out       | valid/ready        | map_word_address, char_index, fine_row, flip_x,
//         |           |                    | priority_bit, palette_base
// cfg     | in        | cfg_we, no stall   | cfg_index, cfg_data
//
// One transaction per cycle is accepted while the output does not stall; a result is
// formed in the address stage, registered by the memory read, then by the output register.
// Reset clears the configuration registers and pipeline valids, not the video memory.
// A stalled output holds the read stage; input is still taken while the read stage
// can move into the output register.
module bg_tilemap_fetch #(
  parameter int LAYER_ID  = bgtf_pkg::LAYER_ID_DEFAULT,
  parameter int MEM_WORDS = bgtf_pkg::MEM_WORDS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bgtf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bgtf_pkg::CFG_DATA_W-1:0]  cfg_data,
  bgtf_in_if.sink                          in_ch,
  bgtf_out_if.source                       out_ch
);

  localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam logic [15:0] MEM_LIMIT = 16'(MEM_WORDS);
  localparam logic [7:0]  LAYER_PAL = 8'(LAYER_ID << 5);

  // Configuration registers.
  logic [2:0]  screen_mode;
  logic [1:0]  color_depth;
  logic        big_tiles;
  logic [1:0]  map_size;
  logic [15:0] map_base;
  logic [15:0] char_base;
  logic [9:0]  scroll_x;
  logic [9:0]  scroll_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_mode <= '0;
      color_depth <= '0;
      big_tiles   <= '0;
      map_size    <= '0;
      map_base    <= '0;
      char_base   <= '0;
      scroll_x    <= '0;
      scroll_y    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bgtf_pkg::REG_SCREEN_MODE: screen_mode <= cfg_data[2:0];
        bgtf_pkg::REG_COLOR_DEPTH: color_depth <= cfg_data[1:0];
        bgtf_pkg::REG_BIG_TILES:   big_tiles   <= cfg_data[0];
        bgtf_pkg::REG_MAP_SIZE:    map_size    <= cfg_data[1:0];
        bgtf_pkg::REG_MAP_BASE:    map_base    <= cfg_data;
        bgtf_pkg::REG_CHAR_BASE:   char_base   <= cfg_data;
        bgtf_pkg::REG_SCROLL_X:    scroll_x    <= cfg_data[9:0];
        bgtf_pkg::REG_SCROLL_Y:    scroll_y    <= cfg_data[9:0];
      endcase
    end
  end

  // Static tile geometry derived from the registers.
  logic hires, wide, tall;
  assign hires = (screen_mode == bgtf_pkg::MODE_HIRES_A) ||
                 (screen_mode == bgtf_pkg::MODE_HIRES_B);
  assign wide  = hires | big_tiles;
  assign tall  = big_tiles;

  // Address stage: scroll, wrap to the map and form the map word address.
  logic [1:0]  span_sh_x, span_sh_y;
  logic [11:0] span_x, span_y;
  logic [10:0] mask_x, mask_y, hscroll, px_ext, hoff, voff;
  logic [7:0]  tx, ty;
  logic [12:0] scx, scy, pos;
  logic [14:0] word_addr;
  logic        fetch_in_range, write_in_range;

  always_comb begin
    span_sh_x = 2'(hires) + 2'(big_tiles) + 2'(map_size[0]);
    span_sh_y = 2'(hires) + 2'(big_tiles) + 2'(map_size[1]);
    span_x    = (12'd256 << span_sh_x) - 12'd1;
    span_y    = (12'd256 << span_sh_y) - 12'd1;
    mask_x    = span_x[10:0];
    mask_y    = span_y[10:0];
    hscroll   = hires ? {scroll_x, 1'b0} : {1'b0, scroll_x};
    px_ext    = {in_ch.pixel_x[9], in_ch.pixel_x};
    hoff      = (px_ext + hscroll) & mask_x;
    voff      = (11'(in_ch.line_y) + 11'(scroll_y)) & mask_y;
    tx        = wide ? {1'b0, hoff[10:4]} : hoff[10:3];
    ty        = tall ? {1'b0, voff[10:4]} : voff[10:3];
    scx       = map_size[0] ? bgtf_pkg::QUAD_X_OFFSET : 13'd0;
    if (!map_size[1]) begin
      scy = 13'd0;
    end else if (map_size[0]) begin
      scy = bgtf_pkg::QUAD_Y_OFFSET2;
    end else begin
      scy = bgtf_pkg::QUAD_Y_OFFSET;
    end
    pos = {3'b000, ty[4:0], tx[4:0]} + (ty[5] ? scy : 13'd0) + (tx[5] ? scx : 13'd0);
    word_addr      = map_base[15:1] + 15'(pos);
    fetch_in_range = {1'b0, word_addr} < MEM_LIMIT;
    write_in_range = {1'b0, in_ch.write_address} < MEM_LIMIT;
  end

  // Handshake and pipeline control.
  logic in_fire, s1_valid, s1_move, out_valid;
  assign s1_move     = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_move;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid <= in_ch.valid;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Video memory: writes land at acceptance, fetches read the map entry.
  logic [15:0] rdata;

  bgtf_ram #(
    .WIDTH (bgtf_pkg::VDATA_W),
    .DEPTH (MEM_WORDS)
  ) u_vram (
    .clk   (clk),
    .we    (in_fire && (in_ch.operation == bgtf_pkg::OP_WRITE) && write_in_range),
    .waddr (in_ch.write_address[AW-1:0]),
    .wdata (in_ch.write_data),
    .re    (in_fire && (in_ch.operation == bgtf_pkg::OP_FETCH)),
    .raddr (word_addr[AW-1:0]),
    .rdata (rdata)
  );

  // Read stage payload, kept beside the memory read in flight.
  logic        s1_is_write, s1_oob, s1_h3;
  logic [3:0]  s1_v;
  logic [14:0] s1_addr;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_is_write <= (in_ch.operation == bgtf_pkg::OP_WRITE);
      s1_oob      <= !fetch_in_range;
      s1_h3       <= hoff[3];
      s1_v        <= voff[3:0];
      s1_addr     <= word_addr;
    end
  end

  // Decode of the map entry.
  logic [15:0] entry;
  logic        mir_x, mir_y, inc1, inc16;
  logic [2:0]  pal_num;
  logic [7:0]  pal_term, palette;
  logic [9:0]  tn10;
  logic [11:0] cb_tiles, tn;
  logic [12:0] tn_sum;
  logic [2:0]  fine;

  always_comb begin
    entry   = s1_oob ? 16'd0 : rdata;
    mir_y   = entry[15];
    mir_x   = entry[14];
    pal_num = entry[12:10];
    unique case (color_depth)
      bgtf_pkg::DEPTH_2BPP: pal_term = {3'b000, pal_num, 2'b00};
      bgtf_pkg::DEPTH_4BPP: pal_term = {1'b0, pal_num, 4'b0000};
      default:              pal_term = 8'd0;
    endcase
    palette  = ((screen_mode == bgtf_pkg::MODE_LAYER_PAL) ? LAYER_PAL : 8'd0) + pal_term;
    inc1     = wide && (s1_h3 != mir_x);
    inc16    = tall && (s1_v[3] != mir_y);
    tn10     = entry[9:0] + 10'(inc1) + (inc16 ? bgtf_pkg::SUB_TILE_DOWN[9:0] : 10'd0);
    cb_tiles = 12'(char_base >> (3'd4 + 3'(color_depth)));
    tn_sum   = 13'(tn10) + 13'(cb_tiles);
    tn       = tn_sum[11:0] & (12'hfff >> color_depth);
    fine     = mir_y ? ~s1_v[2:0] : s1_v[2:0];
  end

  // Output register; a write transaction reports all zero fields.
  always_ff @(posedge clk) begin
    if (s1_move) begin
      if (s1_is_write) begin
        out_ch.map_word_address <= '0;
        out_ch.char_index       <= '0;
        out_ch.fine_row         <= '0;
        out_ch.flip_x           <= 1'b0;
        out_ch.priority_bit     <= 1'b0;
        out_ch.palette_base     <= '0;
      end else begin
        out_ch.map_word_address <= s1_addr;
        out_ch.char_index       <= tn;
        out_ch.fine_row         <= fine;
        out_ch.flip_x           <= mir_x;
        out_ch.priority_bit     <= entry[13];
        out_ch.palette_base     <= palette;
      end
    end
  end

  assign out_ch.valid = out_valid;

endmodule

// ===== hdl/bgtf_checker.sv =====
// Port-level checks of the tile fetch block.
module bgtf_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [bgtf_pkg::OUT_BITS_W-1:0] out_bits
);

  // A stalled result keeps its fields.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_bits))
    else $error("stalled result changed");

  // Nothing is offered right after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // A transaction taken into an empty output path shows up behind the read stage.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> ##1 out_valid)
    else $error("result missing two cycles after input");

  // With the output draining, the input never stalls.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    out_ready || !out_valid |-> in_ready)
    else $error("input stalled while output drains");

endmodule

bind bg_tilemap_fetch bgtf_checker u_bgtf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_bits  ({out_ch.map_word_address, out_ch.char_index, out_ch.fine_row,
               out_ch.flip_x, out_ch.priority_bit, out_ch.palette_base})
);

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LAYER          = bgtf_pkg::LAYER_ID_DEFAULT;
  localparam int VRAM_WORDS     = bgtf_pkg::MEM_WORDS_DEFAULT;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 80;

  // Codes the package leaves unnamed.
  localparam bit [1:0] DEPTH_8BPP  = 2'd2;
  localparam bit [1:0] DEPTH_CODE3 = 2'd3;
  localparam bit [2:0] MODE_PLAIN  = 3'd1;
  localparam bit [2:0] MODE_MIXED  = 3'd3;
  localparam bit [2:0] MODE_TOP    = 3'd7;

  typedef struct {
    bit        operation;
    bit [9:0]  pixel_x;
    bit [7:0]  line_y;
    bit [14:0] write_address;
    bit [15:0] write_data;
  } tile_req_t;

  typedef struct {
    bit [14:0] map_word_address;
    bit [11:0] char_index;
    bit [2:0]  fine_row;
    bit        flip_x;
    bit        priority_bit;
    bit [7:0]  palette_base;
  } tile_desc_t;

  logic                             clk;
  logic                             rst;
  logic                             cfg_we;
  logic [bgtf_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [bgtf_pkg::CFG_DATA_W-1:0]  cfg_data;

  bgtf_in_if  in_ch ();
  bgtf_out_if out_ch ();

  bg_tilemap_fetch #(
    .LAYER_ID  (LAYER),
    .MEM_WORDS (VRAM_WORDS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Shadow copy of the layer registers.
  bit [2:0]  cfg_mode;
  bit [1:0]  cfg_depth;
  bit        cfg_big;
  bit [1:0]  cfg_msize;
  bit [15:0] cfg_mbase;
  bit [15:0] cfg_cbase;
  bit [9:0]  cfg_sx;
  bit [9:0]  cfg_sy;

  // Shadow of video memory, with a flag for each word that has been written.
  bit [15:0] vram [VRAM_WORDS];
  bit        vram_set [VRAM_WORDS];

  tile_desc_t pending_tiles [$];
  tile_desc_t want_tile;

  int  failures     = 0;
  int  items_sent   = 0;
  int  quiet_cycles = 0;
  int  hold_left    = 0;
  bit  src_gaps     = 1'b1;
  bit  sink_gaps    = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Walks the scroll and map geometry down to the word address of the map entry.
  function automatic bit [14:0] entry_address(input bit [9:0] px_in, input bit [7:0] ly_in,
                                              output int unsigned hoff,
                                              output int unsigned voff,
                                              output int unsigned tw,
                                              output int unsigned th);
    bit          hires;
    int unsigned width, mx, my, scx, scy, hs, px, ly, sy, base, tx, ty, pos, byte_addr;
    hires = (cfg_mode == bgtf_pkg::MODE_HIRES_A) || (cfg_mode == bgtf_pkg::MODE_HIRES_B);
    width = hires ? 512 : 256;
    th = cfg_big ? 4 : 3;
    tw = hires ? 4 : th;
    mx = (th == 4) ? (width << 1) : width;
    my = mx;
    if (cfg_msize[0]) mx = mx << 1;
    if (cfg_msize[1]) my = my << 1;
    mx = mx - 1;
    my = my - 1;
    scx = cfg_msize[0] ? 1024 : 0;
    scy = cfg_msize[1] ? 1024 : 0;
    if (cfg_msize == 2'd3) scy = scy << 1;
    hs = cfg_sx;
    if (hires) hs = hs << 1;
    px = {{22{px_in[9]}}, px_in};
    ly = ly_in;
    sy = cfg_sy;
    hoff = (px + hs) & mx;
    voff = (ly + sy) & my;
    tx = hoff >> tw;
    ty = voff >> th;
    pos = ((ty & 32'h1f) << 5) + (tx & 32'h1f);
    if ((ty & 32'h20) != 0) pos = pos + scy;
    if ((tx & 32'h20) != 0) pos = pos + scx;
    base = cfg_mbase & 16'hfffe;
    byte_addr = (base + (pos << 1)) & 32'hffff;
    return byte_addr[15:1];
  endfunction

  // Expected tile descriptor for one request, from the current shadow state.
  function automatic tile_desc_t predict_tile(input tile_req_t req);
    tile_desc_t  d = '{default: '0};
    int unsigned hoff, voff, tw, th, entry, pal_num, pal, tn, cb, layer_pal, row;
    bit [14:0]   waddr;
    bit          mir_x, mir_y;
    if (req.operation == bgtf_pkg::OP_WRITE) return d;
    waddr = entry_address(req.pixel_x, req.line_y, hoff, voff, tw, th);
    entry = vram[waddr];
    mir_y = entry[15];
    mir_x = entry[14];
    pal_num = (entry >> 10) & 32'h7;
    layer_pal = (cfg_mode == bgtf_pkg::MODE_LAYER_PAL) ? (LAYER << 5) : 0;
    pal = (layer_pal + (pal_num << (32'd2 << cfg_depth))) & 32'hff;
    // Sub-tile selection for 16 pixel wide or tall tiles.
    tn = entry;
    if (tw == 4 && (hoff[3] != mir_x)) tn = tn + 1;
    if (th == 4 && (voff[3] != mir_y)) tn = tn + 16;
    cb = cfg_cbase;
    tn = ((tn & 32'h3ff) + (cb >> (4 + cfg_depth))) & (32'hfff >> cfg_depth);
    row = mir_y ? (voff ^ 32'd7) : voff;
    d.map_word_address = waddr;
    d.char_index       = tn[11:0];
    d.fine_row         = row[2:0];
    d.flip_x           = mir_x;
    d.priority_bit     = entry[13];
    d.palette_base     = pal[7:0];
    return d;
  endfunction

  function automatic bit [9:0] rand_px();
    int v;
    v = int'($urandom_range(518)) - 7;
    return v[9:0];
  endfunction

  function automatic tile_req_t make_write(input bit [14:0] addr, input bit [15:0] data);
    tile_req_t r;
    r.operation     = bgtf_pkg::OP_WRITE;
    r.pixel_x       = 10'($urandom);
    r.line_y        = 8'($urandom);
    r.write_address = addr;
    r.write_data    = data;
    return r;
  endfunction

  function automatic tile_req_t make_fetch(input bit [9:0] px, input bit [7:0] ly);
    tile_req_t r;
    r.operation     = bgtf_pkg::OP_FETCH;
    r.pixel_x       = px;
    r.line_y        = ly;
    r.write_address = 15'($urandom);
    r.write_data    = 16'($urandom);
    return r;
  endfunction

  // Offers one request from a falling edge and returns at the falling edge after
  // the transaction, with valid low.
  task automatic send_item(input tile_req_t req);
    while (src_gaps && $urandom_range(99) < 7) @(negedge clk);
    in_ch.operation     = req.operation;
    in_ch.pixel_x       = req.pixel_x;
    in_ch.line_y        = req.line_y;
    in_ch.write_address = req.write_address;
    in_ch.write_data    = req.write_data;
    in_ch.valid         = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_tiles.push_back(predict_tile(req));
    if (req.operation == bgtf_pkg::OP_WRITE) begin
      vram[req.write_address]     = req.write_data;
      vram_set[req.write_address] = 1'b1;
    end
    items_sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic write_word(input bit [14:0] addr, input bit [15:0] data);
    send_item(make_write(addr, data));
  endtask

  // Places a known map entry under the position, then fetches it.
  task automatic fetch_with_entry(input bit [9:0] px, input bit [7:0] ly,
                                  input bit [15:0] entry);
    int unsigned hoff, voff, tw, th;
    bit [14:0]   addr;
    addr = entry_address(px, ly, hoff, voff, tw, th);
    write_word(addr, entry);
    send_item(make_fetch(px, ly));
  endtask

  // Fetches a position, filling its map word first if it was never written.
  task automatic fetch_at(input bit [9:0] px, input bit [7:0] ly);
    int unsigned hoff, voff, tw, th;
    bit [14:0]   addr;
    addr = entry_address(px, ly, hoff, voff, tw, th);
    if (!vram_set[addr]) write_word(addr, 16'($urandom));
    send_item(make_fetch(px, ly));
  endtask

  task automatic wait_all_results();
    while (pending_tiles.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input bit [bgtf_pkg::CFG_INDEX_W-1:0] idx,
                           input bit [bgtf_pkg::CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      bgtf_pkg::REG_SCREEN_MODE: cfg_mode  = val[2:0];
      bgtf_pkg::REG_COLOR_DEPTH: cfg_depth = val[1:0];
      bgtf_pkg::REG_BIG_TILES:   cfg_big   = val[0];
      bgtf_pkg::REG_MAP_SIZE:    cfg_msize = val[1:0];
      bgtf_pkg::REG_MAP_BASE:    cfg_mbase = val;
      bgtf_pkg::REG_CHAR_BASE:   cfg_cbase = val;
      bgtf_pkg::REG_SCROLL_X:    cfg_sx    = val[9:0];
      bgtf_pkg::REG_SCROLL_Y:    cfg_sy    = val[9:0];
      default: ;
    endcase
  endtask

  // Registers change only once the pipeline has drained.
  task automatic apply_layout(input bit [2:0] mode, input bit [1:0] depth, input bit big,
                              input bit [1:0] msize, input bit [15:0] mbase,
                              input bit [15:0] cbase, input bit [9:0] sx, input bit [9:0] sy);
    wait_all_results();
    write_reg(bgtf_pkg::REG_SCREEN_MODE, 16'(mode));
    write_reg(bgtf_pkg::REG_COLOR_DEPTH, 16'(depth));
    write_reg(bgtf_pkg::REG_BIG_TILES, 16'(big));
    write_reg(bgtf_pkg::REG_MAP_SIZE, 16'(msize));
    write_reg(bgtf_pkg::REG_MAP_BASE, mbase);
    write_reg(bgtf_pkg::REG_CHAR_BASE, cbase);
    write_reg(bgtf_pkg::REG_SCROLL_X, 16'(sx));
    write_reg(bgtf_pkg::REG_SCROLL_Y, 16'(sy));
  endtask

  task automatic apply_random_layout();
    bit [1:0] depth;
    depth = ($urandom_range(9) == 0) ? DEPTH_CODE3 : 2'($urandom_range(2));
    apply_layout(3'($urandom), depth, 1'($urandom), 2'($urandom), 16'($urandom),
                 16'($urandom), 10'($urandom), 10'($urandom));
  endtask

  // Mixture of fetches, entry placements, raw writes and runs along a scanline.
  task automatic random_traffic(input int count);
    int       stop_at, r, k;
    bit [9:0] px;
    bit [7:0] ly;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 50) begin
        fetch_at(rand_px(), 8'($urandom));
      end else if (r < 75) begin
        fetch_with_entry(rand_px(), 8'($urandom), 16'($urandom));
      end else if (r < 88) begin
        write_word(15'($urandom), 16'($urandom));
      end else begin
        px = rand_px();
        ly = 8'($urandom);
        for (k = 0; k < 8; k++) fetch_at(px + 10'(8 * k), ly);
      end
    end
  endtask

  // Reset values, field extremes and plain memory writes.
  task automatic test_field_extremes();
    fetch_with_entry(10'h3f9, 8'd0, 16'hffff);
    fetch_with_entry(10'd511, 8'd255, 16'h0000);
    write_word(15'd0, 16'h0000);
    write_word(15'h7fff, 16'hffff);
  endtask

  // Hi-res with 8 pixel tiles still uses 16 pixel wide tiles.
  task automatic test_hires_narrow_tiles();
    apply_layout(bgtf_pkg::MODE_HIRES_A, bgtf_pkg::DEPTH_4BPP, 1'b0, 2'd0, 16'h0000, 16'h2000,
                 10'd3, 10'd0);
    fetch_with_entry(10'd8, 8'd5, 16'h4123);
    fetch_with_entry(10'd0, 8'd5, 16'h0123);
  endtask

  // Big tiles with vertical and horizontal flip on the sub-tile selection.
  task automatic test_big_tiles_flip();
    apply_layout(MODE_PLAIN, DEPTH_8BPP, 1'b1, 2'd2, 16'h4000, 16'h8000, 10'd0, 10'd12);
    fetch_with_entry(10'd16, 8'd8, 16'h8abc);
    fetch_with_entry(10'd24, 8'd3, 16'hc3ff);
  endtask

  // Depth code three: palette number drops out, narrow character mask.
  task automatic test_depth_three();
    apply_layout(MODE_MIXED, DEPTH_CODE3, 1'b0, 2'd1, 16'h1234, 16'hff80, 10'd600, 10'd77);
    fetch_with_entry(10'd40, 8'd100, 16'h1dff);
  endtask

  // Odd map base, maximum scroll and a four-screen map, so sums wrap.
  task automatic test_odd_base_wrap();
    apply_layout(bgtf_pkg::MODE_HIRES_B, bgtf_pkg::DEPTH_2BPP, 1'b1, 2'd3, 16'hffff, 16'hffff,
                 10'd1023, 10'd1023);
    fetch_with_entry(10'd511, 8'd255, 16'h7fff);
    fetch_with_entry(10'h3f9, 8'd0, 16'h2a55);
  endtask

  // The receiver holds off while requests keep coming, so the pipeline fills.
  task automatic test_output_hold();
    int k;
    apply_random_layout();
    hold_left = HOLD_CYCLES;
    for (k = 0; k < 30; k++) fetch_at(rand_px(), 8'($urandom));
  endtask

  // The sender stops until every result is back, then resumes.
  task automatic test_input_pause();
    apply_random_layout();
    random_traffic(20);
    wait_all_results();
    random_traffic(20);
  endtask

  // Several register settings, the extremes among them, each with random traffic.
  task automatic test_random_streams();
    int phase;
    for (phase = 0; phase < 8; phase++) begin
      src_gaps  = (phase != 0);
      sink_gaps = (phase != 0);
      case (phase)
        0: apply_layout(bgtf_pkg::MODE_LAYER_PAL, bgtf_pkg::DEPTH_2BPP, 1'b0, 2'd0, 16'h0000,
                        16'h0000, 10'd0, 10'd0);
        1: apply_layout(MODE_TOP, DEPTH_8BPP, 1'b1, 2'd3, 16'hffff, 16'hffff, 10'd1023,
                        10'd1023);
        2: apply_layout(bgtf_pkg::MODE_HIRES_A, bgtf_pkg::DEPTH_4BPP, 1'b0, 2'd3,
                        16'($urandom), 16'($urandom), 10'($urandom), 10'($urandom));
        3: apply_layout(bgtf_pkg::MODE_HIRES_B, bgtf_pkg::DEPTH_2BPP, 1'b1, 2'd1,
                        16'($urandom), 16'($urandom), 10'($urandom), 10'($urandom));
        default: apply_random_layout();
      endcase
      random_traffic(100);
    end
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    in_ch.valid         = 1'b0;
    in_ch.operation     = bgtf_pkg::OP_FETCH;
    in_ch.pixel_x       = '0;
    in_ch.line_y        = '0;
    in_ch.write_address = '0;
    in_ch.write_data    = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_field_extremes();
    test_hires_narrow_tiles();
    test_big_tiles_flip();
    test_depth_three();
    test_odd_base_wrap();
    test_output_hold();
    test_input_pause();
    test_random_streams();

    wait_all_results();
    repeat (4) @(negedge clk);
    if (pending_tiles.size() != 0) failures++;
    if (failures == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off when a test asks for one.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = !(sink_gaps && $urandom_range(99) < 7);
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      failures++;
    end
  endtask

  // Each result transaction is compared with the oldest expected descriptor.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_tiles.size() == 0) begin
        $display("%0t: unexpected result, map_word_address %0h", $time,
                 out_ch.map_word_address);
        failures++;
      end else begin
        want_tile = pending_tiles.pop_front();
        check_field("map_word_address", want_tile.map_word_address, out_ch.map_word_address);
        check_field("char_index", want_tile.char_index, out_ch.char_index);
        check_field("fine_row", want_tile.fine_row, out_ch.fine_row);
        check_field("flip_x", want_tile.flip_x, out_ch.flip_x);
        check_field("priority_bit", want_tile.priority_bit, out_ch.priority_bit);
        check_field("palette_base", want_tile.palette_base, out_ch.palette_base);
      end
    end
  end

  // Watchdog on cycles in which no transaction moves on either channel.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cycles);
      $display("tb_top: FAIL");
      $finish;
    end
  end

endmodule
